// File: hdl/rtpw_pkg.sv
// Shared constants, operation codes and orientation codes for the rotated two-plane pixel writer.
package rtpw_pkg;

  // Default panel geometry in physical pixels.
  localparam int unsigned DEF_PANEL_WIDTH  = 800;
  localparam int unsigned DEF_PANEL_HEIGHT = 480;
  localparam int unsigned DEF_ROW_BYTES    = (DEF_PANEL_WIDTH + 7) / 8;
  localparam int unsigned DEF_PLANE_BYTES  = DEF_ROW_BYTES * DEF_PANEL_HEIGHT;

  // Field widths of the command and result ports.
  localparam int unsigned OP_W      = 3;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned BIDX_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 19;
  localparam int unsigned ORIENT_W  = 2;
  // Internal coordinate width; holds a logical end coordinate up to twice the field range.
  localparam int unsigned XCOORD_W  = COORD_W + 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PLOT_MONO = 3'd0;
  localparam logic [OP_W-1:0] OP_PLOT_GRAY = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL_MONO = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL_GRAY = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  // Orientation codes; the unused code behaves as landscape.
  localparam logic [ORIENT_W-1:0] ORI_LANDSCAPE = 2'd0;
  localparam logic [ORIENT_W-1:0] ORI_CW        = 2'd1;
  localparam logic [ORIENT_W-1:0] ORI_CCW       = 2'd2;

  // Byte patterns.
  localparam logic [BYTE_W-1:0] BYTE_WHITE   = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_MSB     = 8'h80;

endpackage

// File: hdl/rtpw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module rtpw_ram #(
  parameter int unsigned WIDTH  = rtpw_pkg::BYTE_W,
  parameter int unsigned DEPTH  = rtpw_pkg::DEF_PLANE_BYTES,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rotated_two_plane_pixel_rect_writer.sv
// Rotated two-plane pixel writer: plots, rectangle fills, clear and byte-pair reads.
// Plot and fill: each clipped pixel's byte pair is read, then modified and written back in
// raster order; a command off the area, or with an unknown code, reports straight from idle.
// Read: the byte pair is read and reported. Clear: one byte of each plane written per cycle.
// After reset a clearing pass over all PLANE_BYTES bytes (48000 by default) whitens both planes;
// busy stays high meanwhile. The receiver cannot stall, so the result strobe lasts one cycle.
module rotated_two_plane_pixel_rect_writer #(
  parameter int unsigned PANEL_WIDTH  = rtpw_pkg::DEF_PANEL_WIDTH,
  parameter int unsigned PANEL_HEIGHT = rtpw_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [rtpw_pkg::ORIENT_W-1:0]       cfg_data,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic [rtpw_pkg::OP_W-1:0]           in_op,
  input  logic [rtpw_pkg::COORD_W-1:0]        in_x_coord,
  input  logic [rtpw_pkg::COORD_W-1:0]        in_y_coord,
  input  logic [rtpw_pkg::COORD_W-1:0]        in_rect_width,
  input  logic [rtpw_pkg::COORD_W-1:0]        in_rect_height,
  input  logic                                in_black,
  input  logic [rtpw_pkg::LEVEL_W-1:0]        in_gray_level,
  input  logic [rtpw_pkg::BIDX_W-1:0]         in_byte_index,
  // Result channel.
  output logic                                out_valid,
  output logic [rtpw_pkg::BYTE_W-1:0]         out_bw_byte,
  output logic [rtpw_pkg::BYTE_W-1:0]         out_gray_byte,
  output logic [rtpw_pkg::COUNT_W-1:0]        out_pixels_written
);

  localparam int unsigned ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int unsigned PLANE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int unsigned ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
  localparam int unsigned CW          = rtpw_pkg::XCOORD_W;
  localparam int unsigned BW          = rtpw_pkg::BYTE_W;
  localparam int unsigned NW          = rtpw_pkg::COUNT_W;
  localparam longint unsigned PIX_TOTAL = longint'(PANEL_WIDTH) * longint'(PANEL_HEIGHT);
  localparam longint unsigned COUNT_MAX = (longint'(1) << NW) - 1;
  localparam logic [NW-1:0]   CLEAR_COUNT =
    NW'((PIX_TOTAL > COUNT_MAX) ? COUNT_MAX : PIX_TOTAL);
  localparam logic [CW-1:0]   PW_C = CW'(PANEL_WIDTH);
  localparam logic [CW-1:0]   PH_C = CW'(PANEL_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_WR    = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_CLR   = 3'd4;

  // Control registers.
  logic [2:0]                    state_r, state_nxt;
  logic [rtpw_pkg::ORIENT_W-1:0] orient_r;
  logic [ADDR_W-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic                          clr_report_r, clr_report_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [CW-1:0]     x0_r, x0_nxt;
  logic [CW-1:0]     xe_r, xe_nxt;
  logic [CW-1:0]     ye_r, ye_nxt;
  logic [CW-1:0]     cx_r, cx_nxt;
  logic [CW-1:0]     cy_r, cy_nxt;
  logic              gray_r, gray_nxt;
  logic              bw_one_r, bw_one_nxt;
  logic              g_one_r, g_one_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [BW-1:0]     mask_r, mask_nxt;
  logic [NW-1:0]     count_r, count_nxt;
  logic [BW-1:0]     out_bw_r, out_bw_nxt;
  logic [BW-1:0]     out_gray_r, out_gray_nxt;
  logic [NW-1:0]     out_count_r, out_count_nxt;

  // RAM ports.
  logic              bw_we, gray_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [BW-1:0]     bw_wdata, gray_wdata, bw_rdata, gray_rdata;

  // Address mapping signals.
  logic [CW-1:0]     lx, ly, px, py;
  logic [ADDR_W-1:0] pix_idx;
  logic [BW-1:0]     pix_mask;

  // Command decode signals.
  logic              portrait, in_plot, in_gray;
  logic [CW-1:0]     lw, lh, w_eff, h_eff, xsum, ysum, xe_in, ye_in;
  logic [CW-1:0]     cx_inc, cy_inc;
  logic              nonempty;

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_bw_byte        = out_bw_r;
  assign out_gray_byte      = out_gray_r;
  assign out_pixels_written = out_count_r;

  // Logical area size follows the orientation.
  assign portrait = (orient_r == rtpw_pkg::ORI_CW) || (orient_r == rtpw_pkg::ORI_CCW);
  assign lw       = portrait ? PH_C : PW_C;
  assign lh       = portrait ? PW_C : PH_C;

  // Decode of the incoming command; a plot is a one-pixel rectangle.
  assign in_plot = (in_op == rtpw_pkg::OP_PLOT_MONO) || (in_op == rtpw_pkg::OP_PLOT_GRAY);
  assign in_gray = (in_op == rtpw_pkg::OP_PLOT_GRAY) || (in_op == rtpw_pkg::OP_FILL_GRAY);
  assign w_eff   = in_plot ? CW'(1) : CW'(in_rect_width);
  assign h_eff   = in_plot ? CW'(1) : CW'(in_rect_height);
  assign xsum    = CW'(in_x_coord) + w_eff;
  assign ysum    = CW'(in_y_coord) + h_eff;
  assign xe_in   = (xsum > lw) ? lw : xsum;
  assign ye_in   = (ysum > lh) ? lh : ysum;
  assign nonempty = (CW'(in_x_coord) < xe_in) && (CW'(in_y_coord) < ye_in);

  assign cx_inc = cx_r + CW'(1);
  assign cy_inc = cy_r + CW'(1);

  // Logical to physical mapping of the pixel being addressed.
  assign lx = (state_r == ST_IDLE) ? CW'(in_x_coord) : cx_r;
  assign ly = (state_r == ST_IDLE) ? CW'(in_y_coord) : cy_r;

  always_comb begin
    unique case (orient_r)
      rtpw_pkg::ORI_CW: begin
        px = PW_C - CW'(1) - ly;
        py = lx;
      end
      rtpw_pkg::ORI_CCW: begin
        px = ly;
        py = PH_C - CW'(1) - lx;
      end
      default: begin
        px = lx;
        py = ly;
      end
    endcase
  end

  assign pix_idx  = ADDR_W'(py) * ADDR_W'(ROW_BYTES) + ADDR_W'(px >> 3);
  assign pix_mask = rtpw_pkg::BYTE_MSB >> px[2:0];

  // Read address: the requested byte for a read command, else the mapped pixel.
  assign raddr = ((state_r == ST_IDLE) && (in_op == rtpw_pkg::OP_READ)) ?
                 ADDR_W'(in_byte_index) : pix_idx;

  // Write side: the clearing pass writes white, the modify step sets or clears one bit.
  always_comb begin
    if (state_r == ST_CLR) begin
      waddr      = clr_cnt_r;
      bw_we      = 1'b1;
      gray_we    = 1'b1;
      bw_wdata   = rtpw_pkg::BYTE_WHITE;
      gray_wdata = rtpw_pkg::BYTE_WHITE;
    end else begin
      waddr      = idx_r;
      bw_we      = (state_r == ST_WR);
      gray_we    = (state_r == ST_WR) && gray_r;
      bw_wdata   = bw_one_r ? (bw_rdata | mask_r) : (bw_rdata & ~mask_r);
      gray_wdata = g_one_r ? (gray_rdata | mask_r) : (gray_rdata & ~mask_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    out_valid_nxt  = 1'b0;
    x0_nxt         = x0_r;
    xe_nxt         = xe_r;
    ye_nxt         = ye_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    gray_nxt       = gray_r;
    bw_one_nxt     = bw_one_r;
    g_one_nxt      = g_one_r;
    rd_ok_nxt      = rd_ok_r;
    idx_nxt        = idx_r;
    mask_nxt       = mask_r;
    count_nxt      = count_r;
    out_bw_nxt     = out_bw_r;
    out_gray_nxt   = out_gray_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Latch the command; the first pixel read goes out in this cycle.
          x0_nxt     = CW'(in_x_coord);
          xe_nxt     = xe_in;
          ye_nxt     = ye_in;
          cx_nxt     = CW'(in_x_coord);
          cy_nxt     = CW'(in_y_coord);
          gray_nxt   = in_gray;
          bw_one_nxt = in_gray ? in_gray_level[1] : !in_black;
          g_one_nxt  = in_gray_level[0];
          idx_nxt    = pix_idx;
          mask_nxt   = pix_mask;
          count_nxt  = '0;
          rd_ok_nxt  = (32'(in_byte_index) < PLANE_BYTES);
          if ((in_op == rtpw_pkg::OP_PLOT_MONO) || (in_op == rtpw_pkg::OP_PLOT_GRAY) ||
              (in_op == rtpw_pkg::OP_FILL_MONO) || (in_op == rtpw_pkg::OP_FILL_GRAY)) begin
            if (nonempty) begin
              state_nxt = ST_WR;
            end else begin
              out_valid_nxt = 1'b1;
              out_bw_nxt    = rtpw_pkg::BYTE_ZERO;
              out_gray_nxt  = rtpw_pkg::BYTE_ZERO;
              out_count_nxt = '0;
            end
          end else if (in_op == rtpw_pkg::OP_CLEAR) begin
            state_nxt      = ST_CLR;
            clr_cnt_nxt    = '0;
            clr_report_nxt = 1'b1;
          end else if (in_op == rtpw_pkg::OP_READ) begin
            state_nxt = ST_RDATA;
          end else begin
            // Unknown operation: no change, an all-zero result.
            out_valid_nxt = 1'b1;
            out_bw_nxt    = rtpw_pkg::BYTE_ZERO;
            out_gray_nxt  = rtpw_pkg::BYTE_ZERO;
            out_count_nxt = '0;
          end
        end
      end

      ST_RD: begin
        // Read of the next pixel's byte pair.
        idx_nxt   = pix_idx;
        mask_nxt  = pix_mask;
        state_nxt = ST_WR;
      end

      ST_WR: begin
        // The byte pair is back; the write happens at this edge. Step the raster walk.
        if (count_r != '1) begin
          count_nxt = count_r + NW'(1);
        end
        if (cx_inc < xe_r) begin
          cx_nxt    = cx_inc;
          state_nxt = ST_RD;
        end else if (cy_inc < ye_r) begin
          cx_nxt    = x0_r;
          cy_nxt    = cy_inc;
          state_nxt = ST_RD;
        end else begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_bw_nxt    = rtpw_pkg::BYTE_ZERO;
          out_gray_nxt  = rtpw_pkg::BYTE_ZERO;
          out_count_nxt = (count_r != '1) ? (count_r + NW'(1)) : count_r;
        end
      end

      ST_RDATA: begin
        // Read result; an index beyond the plane reads as zero.
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_bw_nxt    = rd_ok_r ? bw_rdata : rtpw_pkg::BYTE_ZERO;
        out_gray_nxt  = rd_ok_r ? gray_rdata : rtpw_pkg::BYTE_ZERO;
        out_count_nxt = '0;
      end

      ST_CLR: begin
        // One byte of each plane per cycle; a clear command reports at the end.
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt      = ST_IDLE;
          clr_report_nxt = 1'b0;
          if (clr_report_r) begin
            out_valid_nxt = 1'b1;
            out_bw_nxt    = rtpw_pkg::BYTE_ZERO;
            out_gray_nxt  = rtpw_pkg::BYTE_ZERO;
            out_count_nxt = CLEAR_COUNT;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      orient_r     <= rtpw_pkg::ORI_LANDSCAPE;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        orient_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x0_r        <= x0_nxt;
    xe_r        <= xe_nxt;
    ye_r        <= ye_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    gray_r      <= gray_nxt;
    bw_one_r    <= bw_one_nxt;
    g_one_r     <= g_one_nxt;
    rd_ok_r     <= rd_ok_nxt;
    idx_r       <= idx_nxt;
    mask_r      <= mask_nxt;
    count_r     <= count_nxt;
    out_bw_r    <= out_bw_nxt;
    out_gray_r  <= out_gray_nxt;
    out_count_r <= out_count_nxt;
  end

  // Black/white plane.
  rtpw_ram #(
    .WIDTH (BW),
    .DEPTH (PLANE_BYTES)
  ) u_bw_ram (
    .clk   (clk),
    .we    (bw_we),
    .waddr (waddr),
    .wdata (bw_wdata),
    .raddr (raddr),
    .rdata (bw_rdata)
  );

  // Second gray plane.
  rtpw_ram #(
    .WIDTH (BW),
    .DEPTH (PLANE_BYTES)
  ) u_gray_ram (
    .clk   (clk),
    .we    (gray_we),
    .waddr (waddr),
    .wdata (gray_wdata),
    .raddr (raddr),
    .rdata (gray_rdata)
  );

endmodule
